[sv/rff_pkg.sv]
// Shared types and constants of the correction-frame fragmenter.
// Used by rff_ctrl, rff_dp and the top level; depends on nothing.
`default_nettype none
package rff_pkg;

  localparam int FRAGMENT_BYTES      = 180;
  localparam int MAX_FRAGMENTS       = 4;
  localparam int MAX_ASSEMBLED_BYTES = 720;
  localparam int MAX_RESULTS         = 23;

  localparam int LEN_W  = 12;
  localparam int PLEN_W = 8;
  localparam int SEQ_W  = 8;
  localparam int FID_W  = 3;
  localparam int CNT_W  = $clog2(MAX_RESULTS);

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_TERM
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // take a new frame length
    logic push_data;  // emit one data descriptor
    logic push_term;  // emit the empty terminator
    logic last;       // descriptor being pushed closes the frame
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic len_zero;   // offered frame is empty
    logic out_free;   // output register can take a descriptor
    logic data_last;  // current data descriptor is the frame's final one
    logic need_term;  // current data descriptor is final but a terminator follows
  } dp_status_t;

endpackage
`default_nettype wire

[sv/rtcm_frame_fragmenter.sv]
// Top level of the correction-frame fragmenter: controller plus datapath.
// Depends on rff_pkg, rff_ctrl and rff_dp.
//
// Each accepted item is the byte length of one correction frame; the block
// answers with packet descriptors (flags, payload offset, payload length,
// tlast on the frame's final descriptor) for a DMA that moves the bytes.
// Frames of up to 180 bytes give one unfragmented packet, frames of up to
// 720 bytes give up to four fragments sharing one sequence number (plus an
// empty terminator on an exact multiple of 180 below four fragments), and
// longer frames give unfragmented chunks of up to 180 bytes, each numbered.
// An empty frame is taken and gives nothing. A non-empty frame is loaded,
// then the controller's emit loop gives one descriptor per cycle while the
// output is drained; a stall on the output holds the loop. in_tready is
// high only between frames.
`default_nettype none
module rtcm_frame_fragmenter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [11:0] frame_length, [15:12] zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [7:0] packet_flags, [19:8] payload_offset,
                                       // [27:20] payload_length, [31:28] zero
  output logic             out_tlast   // last_packet
);

  rff_pkg::ctrl_cmd_t  cmd;
  rff_pkg::dp_status_t st;

  logic [7:0]                  flags;
  logic [rff_pkg::LEN_W-1:0]   offset;
  logic [rff_pkg::PLEN_W-1:0]  plen;

  rff_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .st       (st),
    .cmd      (cmd)
  );

  rff_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_len     (in_tdata[rff_pkg::LEN_W-1:0]),
    .cmd        (cmd),
    .st         (st),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_flags  (flags),
    .out_offset (offset),
    .out_plen   (plen),
    .out_last   (out_tlast)
  );

  assign out_tdata = {4'b0000, plen, offset, flags};

endmodule
`default_nettype wire

[sv/rff_ctrl.sv]
// Controller of the fragmenter: sequences load, data and terminator pushes.
// Depends on rff_pkg for the state and command/status types.
`default_nettype none
module rff_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire rff_pkg::dp_status_t st,
  output rff_pkg::ctrl_cmd_t      cmd
);

  rff_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rff_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      rff_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        // an empty frame is consumed without output
        if (in_valid && !st.len_zero) begin
          cmd.load  = 1'b1;
          state_nxt = rff_pkg::ST_EMIT;
        end
      end
      rff_pkg::ST_EMIT: begin
        if (st.out_free) begin
          cmd.push_data = 1'b1;
          cmd.last      = st.data_last;
          if (st.data_last) begin
            state_nxt = rff_pkg::ST_IDLE;
          end else if (st.need_term) begin
            state_nxt = rff_pkg::ST_TERM;
          end
        end
      end
      rff_pkg::ST_TERM: begin
        if (st.out_free) begin
          cmd.push_term = 1'b1;
          cmd.last      = 1'b1;
          state_nxt     = rff_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rff_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[sv/rff_dp.sv]
// Datapath of the fragmenter: frame registers, offset/length arithmetic,
// sequence counter and the output descriptor register. Depends on rff_pkg.
`default_nettype none
module rff_dp (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [rff_pkg::LEN_W-1:0]    in_len,
  input  wire rff_pkg::ctrl_cmd_t           cmd,
  output rff_pkg::dp_status_t               st,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [7:0]                        out_flags,
  output logic [rff_pkg::LEN_W-1:0]         out_offset,
  output logic [rff_pkg::PLEN_W-1:0]        out_plen,
  output logic                              out_last
);

  localparam logic [rff_pkg::LEN_W-1:0] STEP_C      = rff_pkg::LEN_W'(rff_pkg::FRAGMENT_BYTES);
  localparam logic [rff_pkg::LEN_W-1:0] ASM_MAX_C   = rff_pkg::LEN_W'(rff_pkg::MAX_ASSEMBLED_BYTES);
  localparam logic [rff_pkg::FID_W-1:0] MAX_FRAG_C  = rff_pkg::FID_W'(rff_pkg::MAX_FRAGMENTS);
  localparam logic [rff_pkg::CNT_W-1:0] CNT_LAST_C  = rff_pkg::CNT_W'(rff_pkg::MAX_RESULTS - 1);

  logic [rff_pkg::LEN_W-1:0]  len_r;
  logic [rff_pkg::LEN_W-1:0]  off_r;
  logic [rff_pkg::FID_W-1:0]  fid_r;
  logic [rff_pkg::CNT_W-1:0]  cnt_r;
  logic                       frag_r;
  logic [rff_pkg::SEQ_W-1:0]  seq_r;
  logic                       out_valid_r;
  logic [7:0]                 flags_r;
  logic [rff_pkg::LEN_W-1:0]  offset_r;
  logic [rff_pkg::PLEN_W-1:0] plen_r;
  logic                       last_r;

  logic [rff_pkg::LEN_W-1:0]  rem;
  logic [rff_pkg::LEN_W-1:0]  chunk;
  logic [rff_pkg::FID_W-1:0]  fid_nxt;
  logic                       at_limit;
  logic                       final_chunk;
  logic                       need_term;
  logic                       seq_inc;
  logic [7:0]                 flags_cur;

  assign rem         = len_r - off_r;
  assign chunk       = (rem < STEP_C) ? rem : STEP_C;
  assign fid_nxt     = fid_r + 1'b1;
  assign at_limit    = (cnt_r == CNT_LAST_C);
  assign final_chunk = (rem <= STEP_C);
  // an exact multiple ends on a full chunk; add a terminator if ids remain
  assign need_term   = frag_r && (rem == STEP_C) && (fid_nxt < MAX_FRAG_C) && !at_limit;

  assign st.len_zero  = (in_len == '0);
  assign st.out_free  = !out_valid_r || out_ready;
  assign st.data_last = (final_chunk && !need_term) || at_limit;
  assign st.need_term = need_term;

  always_comb begin
    flags_cur = {seq_r[4:0], 3'b000};
    if (frag_r) begin
      flags_cur[0]   = 1'b1;
      flags_cur[2:1] = cmd.push_term ? fid_r[1:0] : fid_r[1:0];
    end
  end

  // unfragmented chunks each take a number; a fragmented frame takes one at its end
  assign seq_inc = (cmd.push_data && (!frag_r || cmd.last)) || cmd.push_term;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (seq_inc) begin
        seq_r <= seq_r + 1'b1;
      end
      if (cmd.push_data || cmd.push_term) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      len_r  <= in_len;
      off_r  <= '0;
      fid_r  <= '0;
      cnt_r  <= '0;
      frag_r <= (in_len > STEP_C) && (in_len <= ASM_MAX_C);
    end else if (cmd.push_data) begin
      off_r <= off_r + chunk;
      fid_r <= fid_nxt;
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.push_data) begin
      flags_r  <= flags_cur;
      offset_r <= off_r;
      plen_r   <= chunk[rff_pkg::PLEN_W-1:0];
      last_r   <= cmd.last;
    end else if (cmd.push_term) begin
      flags_r  <= flags_cur;
      offset_r <= len_r;
      plen_r   <= '0;
      last_r   <= 1'b1;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_flags  = flags_r;
  assign out_offset = offset_r;
  assign out_plen   = plen_r;
  assign out_last   = last_r;

endmodule
`default_nettype wire

[sv/rff_checker.sv]
// Port-level checks of the fragmenter, bound to the top level.
// Depends only on the top level's port names.
`default_nettype none
module rff_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [15:0] in_tdata,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic        out_tlast
);

  // stalled item stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped under stall");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("output item changed under stall");

  // a non-empty frame blocks the input once it is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tdata[11:0] != 12'd0) |=> !in_tready)
    else $error("input accepted while a frame is in progress");

  // an empty descriptor is only the fragmented terminator, closing its frame
  a_term: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[27:20] == 8'd0) |-> out_tlast && out_tdata[0])
    else $error("empty descriptor that is not a final terminator");

endmodule

bind rtcm_frame_fragmenter rff_checker u_rff_checker (.*);
`default_nettype wire
